// ===== rtl/core/mmio_rdc_pkg.sv =====
// Package for the MMIO range decoder and checker.
// Holds the operation and status codes and the controller state type.
// Used by the controller, the datapath and the top level.
package mmio_rdc_pkg;

   typedef enum logic [1:0] {
      OP_REGISTER   = 2'd0,
      OP_UNREGISTER = 2'd1,
      OP_CLEAR      = 2'd2,
      OP_ACCESS     = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_FORWARD    = 4'd0,
      ST_MISS       = 4'd1,
      ST_BADOP      = 4'd2,
      ST_OVERRUN    = 4'd3,
      ST_READONLY   = 4'd4,
      ST_MISALIGN   = 4'd5,
      ST_REGISTERED = 4'd6,
      ST_ALREADY    = 4'd7,
      ST_INVALID    = 4'd8,
      ST_COLLISION  = 4'd9,
      ST_FULL       = 4'd10,
      ST_REMOVED    = 4'd11,
      ST_CLEARED    = 4'd12,
      ST_NOTFOUND   = 4'd13
   } status_type;

   localparam logic [2:0] CODE_PUT_FULL    = 3'd0;
   localparam logic [2:0] CODE_PUT_PARTIAL = 3'd1;
   localparam logic [2:0] CODE_GET         = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MOD,
      S_FINISH,
      S_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic mod_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic need_mod;
      logic mod_last;
   } stat_type;

endpackage

// ===== rtl/core/mmio_range_decoder_checker.sv =====
// A response is offered after the request transfer, a scan over all
// TABLE_ENTRIES table entries and a finish step; bus accesses also run the
// bit-serial remainder after the table scan, before the finish step.
// One item at a time: the next request is taken only after the response
// has been accepted.
// Synchronous active-high reset clears the valid bits, counters and controller.
module mmio_range_decoder_checker
   import mmio_rdc_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // op[1:0]
   input  logic [1:0]   req_tuser,
   // device_id[7:0], range_base[71:8], range_size[135:72],
   // read_only[136], align_bytes[152:137], address[216:153],
   // access_code[219:217], size_code[221:220], zero fill [223:222]
   input  logic [223:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[3:0], target_device[11:4], denied[12], error_total[44:13],
   // read_total[76:45], write_total[108:77], zero fill [111:109]
   output logic [111:0] rsp_tdata
);

   cmd_type  cmd;
   stat_type stat;
   logic [3:0]  status;
   logic [7:0]  target_device;
   logic        denied;
   logic [31:0] error_total, read_total, write_total;

   mmio_rdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mmio_rdc_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .op            (req_tuser),
      .device_id     (req_tdata[7:0]),
      .range_base    (req_tdata[71:8]),
      .range_size    (req_tdata[135:72]),
      .read_only     (req_tdata[136]),
      .align_bytes   (req_tdata[152:137]),
      .address       (req_tdata[216:153]),
      .access_code   (req_tdata[219:217]),
      .size_code     (req_tdata[221:220]),
      .status        (status),
      .target_device (target_device),
      .denied        (denied),
      .error_total   (error_total),
      .read_total    (read_total),
      .write_total   (write_total)
   );

   assign rsp_tdata = {3'b000, write_total, read_total, error_total, denied,
                       target_device, status};

endmodule

// ===== rtl/core/mmio_rdc_ctrl.sv =====
// Controller state machine of the MMIO range decoder and checker.
// Steps the datapath through table scan, remainder and result phases.
// Depends on mmio_rdc_pkg.
module mmio_rdc_ctrl
   import mmio_rdc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   output logic     out_valid,
   input  logic     out_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (stat.scan_last) state_in = stat.need_mod ? S_MOD : S_FINISH;
         end
         S_MOD: begin
            if (stat.mod_last) state_in = S_FINISH;
         end
         S_FINISH: state_in = S_OUT;
         S_OUT: begin
            if (out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      in_ready     = 1'b0;
      out_valid    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready  = 1'b1;
            cmd.start = in_valid;
         end
         S_SCAN:   cmd.scan = 1'b1;
         S_MOD:    cmd.mod_step = 1'b1;
         S_FINISH: cmd.finish = 1'b1;
         S_OUT:    out_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

// ===== rtl/core/mmio_rdc_dp.sv =====
// Datapath of the MMIO range decoder and checker: range table, scan logic,
// bit-serial remainder unit and saturating counters.
// Depends on mmio_rdc_pkg.
module mmio_rdc_dp
   import mmio_rdc_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [1:0]  op,
   input  logic [7:0]  device_id,
   input  logic [63:0] range_base,
   input  logic [63:0] range_size,
   input  logic        read_only,
   input  logic [15:0] align_bytes,
   input  logic [63:0] address,
   input  logic [2:0]  access_code,
   input  logic [1:0]  size_code,
   output logic [3:0]  status,
   output logic [7:0]  target_device,
   output logic        denied,
   output logic [31:0] error_total,
   output logic [31:0] read_total,
   output logic [31:0] write_total
);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [63:0] base_ff  [TABLE_ENTRIES];
   logic [63:0] end_ff   [TABLE_ENTRIES];
   logic [7:0]  dev_ff   [TABLE_ENTRIES];
   logic        ro_ff    [TABLE_ENTRIES];
   logic [15:0] align_ff [TABLE_ENTRIES];

   logic [1:0]  op_ff;
   logic [7:0]  dev_id_ff;
   logic [63:0] rbase_ff, rend_ff, addr_ff;
   logic        rro_ff, rbad_ff;
   logic [15:0] ralign_ff;
   logic [2:0]  code_ff;
   logic [1:0]  size_ff;
   logic [IW-1:0] idx_ff;
   logic        dec_found_ff, free_found_ff, hit_found_ff;
   logic [IW-1:0] dec_idx_ff, free_idx_ff, hit_idx_ff;
   logic [63:0] dec_base_ff;
   logic        dec_match_ff;
   logic [63:0] mrem_ff;
   logic [6:0]  mcnt_ff;
   logic [3:0]  status_ff;
   logic [7:0]  target_ff;
   logic        denied_ff;
   logic [31:0] err_ff, rd_ff, wr_ff;

   logic [64:0] sum;
   logic        e_valid, e_hit, e_access_hit;
   logic [64:0] mtrial;
   logic [63:0] mshift;
   logic        is_read, is_put;
   logic [63:0] last_off;
   logic [64:0] addr_last;
   status_type  st;

   assign sum = {1'b0, range_base} + {1'b0, range_size};
   assign e_valid = valid_ff[idx_ff];
   assign e_hit = e_valid && ((dev_ff[idx_ff] == dev_id_ff) ||
                  ((rbase_ff < end_ff[idx_ff]) && (base_ff[idx_ff] < rend_ff)));
   assign e_access_hit = e_valid && (addr_ff >= base_ff[idx_ff]) &&
                         (addr_ff < end_ff[idx_ff]);

   assign mshift = {mrem_ff[62:0], addr_ff[~mcnt_ff[5:0]]};
   assign mtrial = {1'b0, mshift} - {49'd0, align_ff[hit_idx_ff]};

   assign stat.scan_last = (idx_ff == LAST_IDX);
   assign stat.need_mod  = (op_ff == OP_ACCESS);
   assign stat.mod_last  = (mcnt_ff == 7'd63);

   assign is_read  = (code_ff == CODE_GET);
   assign is_put   = (code_ff == CODE_PUT_FULL) || (code_ff == CODE_PUT_PARTIAL);
   assign last_off = (64'd1 << size_ff) - 64'd1;
   assign addr_last = {1'b0, addr_ff} + {1'b0, last_off};

   always_comb begin
      st = ST_CLEARED;
      case (op_ff)
         OP_REGISTER: begin
            if (rbad_ff) st = ST_INVALID;
            else if (dec_found_ff) st = dec_match_ff ? ST_ALREADY : ST_COLLISION;
            else if (!free_found_ff) st = ST_FULL;
            else st = ST_REGISTERED;
         end
         OP_UNREGISTER: st = dec_found_ff ? ST_REMOVED : ST_NOTFOUND;
         OP_CLEAR: st = ST_CLEARED;
         default: begin
            if (!hit_found_ff) st = ST_MISS;
            else if (!is_read && !is_put) st = ST_BADOP;
            else if (addr_last[64] || (addr_last[63:0] >= end_ff[hit_idx_ff]))
               st = ST_OVERRUN;
            else if (is_put && ro_ff[hit_idx_ff]) st = ST_READONLY;
            else if ((align_ff[hit_idx_ff] > 16'd1) && (mrem_ff != 64'd0))
               st = ST_MISALIGN;
            else st = ST_FORWARD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff     <= op;
         dev_id_ff <= device_id;
         rbase_ff  <= range_base;
         rend_ff   <= sum[63:0];
         rbad_ff   <= (range_size == 64'd0) || sum[64];
         rro_ff    <= read_only;
         ralign_ff <= align_bytes;
         addr_ff   <= address;
         code_ff   <= access_code;
         size_ff   <= size_code;
         mrem_ff   <= '0;
         mcnt_ff   <= '0;
      end
      if (cmd.scan) begin
         if (e_access_hit && !hit_found_ff) hit_idx_ff <= idx_ff;
         if (!e_valid && !free_found_ff) free_idx_ff <= idx_ff;
         if (op_ff == OP_REGISTER) begin
            if (e_hit && (!dec_found_ff || base_ff[idx_ff] < dec_base_ff)) begin
               dec_idx_ff   <= idx_ff;
               dec_base_ff  <= base_ff[idx_ff];
               dec_match_ff <= (dev_ff[idx_ff] == dev_id_ff);
            end
         end else if (e_valid && (dev_ff[idx_ff] == dev_id_ff) && !dec_found_ff) begin
            dec_idx_ff <= idx_ff;
         end
      end
      if (cmd.mod_step) begin
         mrem_ff <= mtrial[64] ? mshift : mtrial[63:0];
         mcnt_ff <= mcnt_ff + 7'd1;
      end
      if (cmd.finish) begin
         status_ff <= st;
         target_ff <= '0;
         denied_ff <= 1'b0;
         if (op_ff == OP_ACCESS) begin
            denied_ff <= (st != ST_FORWARD);
            if (st == ST_FORWARD) target_ff <= dev_ff[hit_idx_ff];
         end
         if (op_ff == OP_REGISTER && st == ST_REGISTERED) begin
            base_ff[free_idx_ff]  <= rbase_ff;
            end_ff[free_idx_ff]   <= rend_ff;
            dev_ff[free_idx_ff]   <= dev_id_ff;
            ro_ff[free_idx_ff]    <= rro_ff;
            align_ff[free_idx_ff] <= ralign_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         idx_ff        <= '0;
         dec_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         hit_found_ff  <= 1'b0;
         err_ff        <= '0;
         rd_ff         <= '0;
         wr_ff         <= '0;
      end else begin
         if (cmd.start) begin
            idx_ff        <= '0;
            dec_found_ff  <= 1'b0;
            free_found_ff <= 1'b0;
            hit_found_ff  <= 1'b0;
         end
         if (cmd.scan) begin
            if (!stat.scan_last) idx_ff <= idx_ff + IW'(1);
            if (e_access_hit) hit_found_ff <= 1'b1;
            if (!e_valid) free_found_ff <= 1'b1;
            if (op_ff == OP_REGISTER ? e_hit
                : (e_valid && dev_ff[idx_ff] == dev_id_ff)) dec_found_ff <= 1'b1;
         end
         if (cmd.finish) begin
            case (op_ff)
               OP_REGISTER: begin
                  if (st == ST_REGISTERED) valid_ff[free_idx_ff] <= 1'b1;
               end
               OP_UNREGISTER: begin
                  if (dec_found_ff) valid_ff[dec_idx_ff] <= 1'b0;
               end
               OP_CLEAR: valid_ff <= '0;
               default: begin
                  if (st != ST_FORWARD) begin
                     if (err_ff != 32'hFFFF_FFFF) err_ff <= err_ff + 32'd1;
                  end else if (is_read) begin
                     if (rd_ff != 32'hFFFF_FFFF) rd_ff <= rd_ff + 32'd1;
                  end else begin
                     if (wr_ff != 32'hFFFF_FFFF) wr_ff <= wr_ff + 32'd1;
                  end
               end
            endcase
         end
      end
   end

   assign status        = status_ff;
   assign target_device = target_ff;
   assign denied        = denied_ff;
   assign error_total   = err_ff;
   assign read_total    = rd_ff;
   assign write_total   = wr_ff;

endmodule
